### hdl/aou_pkg.sv
`timescale 1ns / 1ps

package aou_pkg;

  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 32;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_LEARNING_RATE = 4'd0;
  localparam cfg_idx_t CFG_BETA_FIRST    = 4'd1;
  localparam cfg_idx_t CFG_BETA_SECOND   = 4'd2;
  localparam cfg_idx_t CFG_EPSILON       = 4'd3;

  localparam logic [31:0] LEARNING_RATE_RST = 32'd4294967;
  localparam logic [31:0] BETA_FIRST_RST    = 32'd3865470566;
  localparam logic [31:0] BETA_SECOND_RST   = 32'd4290672329;
  localparam logic [23:0] EPSILON_RST       = 24'd1;

  // 1.32 fixed point one
  localparam logic [32:0] ONE_Q32   = 33'h1_0000_0000;
  // largest step a single update may take
  localparam logic [33:0] DELTA_MAX = 34'h2_0000_0000;

  typedef struct packed {
    logic [9:0]         element_index;
    logic signed [31:0] gradient;
    logic signed [31:0] weight_in;
    logic               step_start;
  } in_beat_t;

  typedef struct packed {
    logic signed [31:0] weight_out;
    logic               saturated;
  } out_beat_t;

  typedef struct packed {
    logic [31:0] learning_rate;
    logic [31:0] beta_first;
    logic [31:0] beta_second;
    logic [23:0] epsilon;
  } cfg_t;

  // updated moments and bias corrections of one element
  typedef struct packed {
    logic signed [31:0] m;
    logic [63:0]        v;
    logic [32:0]        corr1;
    logic [32:0]        corr2;
    logic signed [31:0] w;
  } mom_t;

endpackage

### hdl/aou_if.sv
`timescale 1ns / 1ps

interface aou_in_if;
  logic               valid;
  logic               ready;
  aou_pkg::in_beat_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface aou_out_if;
  logic               valid;
  logic               ready;
  aou_pkg::out_beat_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface aou_cfg_if;
  logic                              valid;
  logic                              ready;
  aou_pkg::cfg_idx_t                 index;
  logic [aou_pkg::CFG_DATA_W-1:0]    wdata;

  modport source (output valid, output index, output wdata, input ready);
  modport sink   (input valid, input index, input wdata, output ready);
endinterface

### hdl/adam_optimizer_update.sv
// Adam weight update, one weight per beat. Each input beat names an element,
// brings its gradient and weight, and may open a new step (advancing the beta
// powers); one beat with the updated, saturated weight comes out for each.
// Beats enter at one per cycle while no result is held waiting at the output,
// and each result passes the bit-per-stage dividers and root. Input is held
// off while one of the three previous beats still in the moment
// read-modify-write names the same element, and after reset while the
// moment stores are cleared, one entry per cycle.
// Configuration writes are taken at any time and should land while idle.
`timescale 1ns / 1ps

module adam_optimizer_update #(
  parameter int unsigned WEIGHT_COUNT = 1024
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  aou_in_if.sink    in_i,
  aou_out_if.source out_o,
  aou_cfg_if.sink   cfg_i
);

  typedef struct packed {
    logic               neg;
    logic signed [31:0] w;
  } wsign_t;

  typedef struct packed {
    logic [63:0]        mhat;
    logic               neg;
    logic signed [31:0] w;
  } root_side_t;

  aou_pkg::cfg_t cfg_q;
  logic          en;

  logic          mom_v;
  aou_pkg::mom_t mom;

  logic [31:0]   mmag;
  wsign_t        mside;

  logic          dm_v;
  logic [63:0]   dm_q;
  wsign_t        dm_side;
  logic [63:0]   dv_q;
  logic          dv_sat;
  logic [63:0]   vhat;

  root_side_t    sq_in, sq_out;
  logic          sq_v;
  logic [31:0]   root;

  logic [32:0]   den_sum;
  logic          p1_v_q;
  logic [32:0]   den1_q;
  logic [63:0]   mul_hi1_q, mul_lo1_q;
  wsign_t        ws1_q;
  logic          p2_v_q;
  logic [32:0]   den2_q;
  logic [95:0]   num2_q;
  wsign_t        ws2_q;

  logic          dd_v;
  logic [33:0]   dd_q;
  logic          dd_sat;
  wsign_t        dd_side;
  logic [33:0]   delta;
  logic signed [34:0] wn;

  logic               out_v_q;
  aou_pkg::out_beat_t out_q;
  aou_pkg::out_beat_t out_d;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.learning_rate <= aou_pkg::LEARNING_RATE_RST;
      cfg_q.beta_first    <= aou_pkg::BETA_FIRST_RST;
      cfg_q.beta_second   <= aou_pkg::BETA_SECOND_RST;
      cfg_q.epsilon       <= aou_pkg::EPSILON_RST;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        aou_pkg::CFG_LEARNING_RATE: cfg_q.learning_rate <= cfg_i.wdata;
        aou_pkg::CFG_BETA_FIRST:    cfg_q.beta_first    <= cfg_i.wdata;
        aou_pkg::CFG_BETA_SECOND:   cfg_q.beta_second   <= cfg_i.wdata;
        aou_pkg::CFG_EPSILON:       cfg_q.epsilon       <= cfg_i.wdata[23:0];
        default: ;
      endcase
    end
  end

  // the whole pipe moves unless a finished result is waiting
  assign en = !out_v_q || out_o.ready;

  aou_moment #(.WEIGHT_COUNT(WEIGHT_COUNT)) u_moment (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_i.valid),
    .in_data_i   (in_i.data),
    .in_ready_o  (in_i.ready),
    .mom_valid_o (mom_v),
    .mom_o       (mom)
  );

  assign mmag      = mom.m[31] ? 32'(-mom.m) : 32'(mom.m);
  assign mside.neg = mom.m[31];
  assign mside.w   = mom.w;

  aou_div #(.N_W(65), .D_W(33), .Q_W(64), .SIDE_W(33)) u_div_mhat (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (mom_v),
    .num_i   ({1'b0, mmag, 32'd0}),
    .den_i   (mom.corr1),
    .side_i  (mside),
    .valid_o (dm_v),
    .quo_o   (dm_q),
    .sat_o   (),
    .side_o  (dm_side)
  );

  aou_div #(.N_W(96), .D_W(33), .Q_W(64), .SIDE_W(1)) u_div_vhat (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (mom_v),
    .num_i   ({mom.v, 32'd0}),
    .den_i   (mom.corr2),
    .side_i  (1'b0),
    .valid_o (),
    .quo_o   (dv_q),
    .sat_o   (dv_sat),
    .side_o  ()
  );

  assign vhat       = dv_sat ? '1 : dv_q;
  assign sq_in.mhat = dm_q;
  assign sq_in.neg  = dm_side.neg;
  assign sq_in.w    = dm_side.w;

  aou_sqrt #(.SIDE_W(97)) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (dm_v),
    .x_i     (vhat),
    .side_i  (sq_in),
    .valid_o (sq_v),
    .root_o  (root),
    .side_o  (sq_out)
  );

  assign den_sum = {1'b0, root} + 33'(cfg_q.epsilon);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_v_q  <= 1'b0;
      p2_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else if (en) begin
      p1_v_q  <= sq_v;
      p2_v_q  <= p1_v_q;
      out_v_q <= dd_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      den1_q    <= (den_sum == 33'd0) ? 33'd1 : den_sum;
      mul_hi1_q <= cfg_q.learning_rate * sq_out.mhat[63:32];
      mul_lo1_q <= cfg_q.learning_rate * sq_out.mhat[31:0];
      ws1_q.neg <= sq_out.neg;
      ws1_q.w   <= sq_out.w;

      den2_q <= den1_q;
      num2_q <= {mul_hi1_q, 32'd0} + {32'd0, mul_lo1_q};
      ws2_q  <= ws1_q;

      out_q <= out_d;
    end
  end

  aou_div #(.N_W(96), .D_W(41), .Q_W(34), .SIDE_W(33)) u_div_delta (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (p2_v_q),
    .num_i   (num2_q),
    .den_i   ({den2_q, 8'd0}),
    .side_i  (ws2_q),
    .valid_o (dd_v),
    .quo_o   (dd_q),
    .sat_o   (dd_sat),
    .side_o  (dd_side)
  );

  assign delta = (dd_sat || (dd_q > aou_pkg::DELTA_MAX)) ? aou_pkg::DELTA_MAX : dd_q;
  assign wn    = dd_side.neg ? (35'(dd_side.w) + $signed({1'b0, delta}))
                             : (35'(dd_side.w) - $signed({1'b0, delta}));

  always_comb begin
    if (wn > 35'sd2147483647) begin
      out_d.weight_out = 32'sh7FFF_FFFF;
      out_d.saturated  = 1'b1;
    end else if (wn < -35'sd2147483648) begin
      out_d.weight_out = 32'sh8000_0000;
      out_d.saturated  = 1'b1;
    end else begin
      out_d.weight_out = wn[31:0];
      out_d.saturated  = 1'b0;
    end
  end

  assign out_o.valid = out_v_q;
  assign out_o.data  = out_q;

endmodule

### hdl/aou_div.sv
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per stage. sat_o flags a quotient that
// would need more than Q_W bits.
module aou_div #(
  parameter int unsigned N_W    = 96,
  parameter int unsigned D_W    = 33,
  parameter int unsigned Q_W    = 64,
  parameter int unsigned SIDE_W = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [N_W-1:0]    num_i,
  input  logic [D_W-1:0]    den_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  output logic [Q_W-1:0]    quo_o,
  output logic              sat_o,
  output logic [SIDE_W-1:0] side_o
);

  logic [Q_W:0]        vld_q;
  logic [D_W-1:0]      rem_q  [Q_W+1];
  logic [Q_W-1:0]      acc_q  [Q_W+1];
  logic [D_W-1:0]      den_q  [Q_W+1];
  logic                sat_q  [Q_W+1];
  logic [SIDE_W-1:0]   side_q [Q_W+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[Q_W-1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= D_W'(num_i[N_W-1:Q_W]);
      acc_q[0]  <= num_i[Q_W-1:0];
      den_q[0]  <= den_i;
      sat_q[0]  <= (num_i[N_W-1:Q_W] >= den_i);
      side_q[0] <= side_i;
    end
  end

  for (genvar s = 1; s <= Q_W; s++) begin : g_stage
    logic [D_W:0] trial;
    logic         ge;

    always_comb begin
      trial = {rem_q[s-1], acc_q[s-1][Q_W-1]};
      ge    = (trial >= {1'b0, den_q[s-1]});
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s]  <= D_W'(ge ? (trial - {1'b0, den_q[s-1]}) : trial);
        acc_q[s]  <= {acc_q[s-1][Q_W-2:0], ge};
        den_q[s]  <= den_q[s-1];
        sat_q[s]  <= sat_q[s-1];
        side_q[s] <= side_q[s-1];
      end
    end
  end

  assign valid_o = vld_q[Q_W];
  assign quo_o   = acc_q[Q_W];
  assign sat_o   = sat_q[Q_W];
  assign side_o  = side_q[Q_W];

endmodule

### hdl/aou_sqrt.sv
`timescale 1ns / 1ps

// Integer square root of a 64-bit value, two radicand bits per stage.
module aou_sqrt #(
  parameter int unsigned SIDE_W = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [63:0]       x_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  output logic [31:0]       root_o,
  output logic [SIDE_W-1:0] side_o
);

  logic [32:0]       vld_q;
  logic [33:0]       rem_q  [33];
  logic [31:0]       root_q [33];
  logic [63:0]       x_q    [33];
  logic [SIDE_W-1:0] side_q [33];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[31:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= '0;
      root_q[0] <= '0;
      x_q[0]    <= x_i;
      side_q[0] <= side_i;
    end
  end

  for (genvar s = 1; s <= 32; s++) begin : g_stage
    logic [35:0] trial;
    logic [35:0] sub;
    logic        ge;

    always_comb begin
      trial = {rem_q[s-1], x_q[s-1][63:62]};
      sub   = {2'b00, root_q[s-1], 2'b01};
      ge    = (trial >= sub);
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s]  <= 34'(ge ? (trial - sub) : trial);
        root_q[s] <= {root_q[s-1][30:0], ge};
        x_q[s]    <= {x_q[s-1][61:0], 2'b00};
        side_q[s] <= side_q[s-1];
      end
    end
  end

  assign valid_o = vld_q[32];
  assign root_o  = root_q[32];
  assign side_o  = side_q[32];

endmodule

### hdl/aou_moment.sv
`timescale 1ns / 1ps

// Moment stores, beta powers and the read-modify-write of both moments.
module aou_moment #(
  parameter int unsigned WEIGHT_COUNT = 1024
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  aou_pkg::cfg_t     cfg_i,
  input  logic              in_valid_i,
  input  aou_pkg::in_beat_t in_data_i,
  output logic              in_ready_o,
  output logic              mom_valid_o,
  output aou_pkg::mom_t     mom_o
);

  localparam int unsigned IDX_W = (WEIGHT_COUNT > 1) ? $clog2(WEIGHT_COUNT) : 1;

  logic [31:0] m_mem [WEIGHT_COUNT];
  logic [63:0] v_mem [WEIGHT_COUNT];

  logic             clr_busy_q;
  logic [IDX_W-1:0] clr_cnt_q;

  logic [32:0] pa_q, pb_q;
  logic [64:0] pa_prod, pb_prod;
  logic [32:0] pa_new, pb_new;

  logic [IDX_W-1:0] rd_addr;
  logic             hazard;
  logic             accept;

  // stage 1
  logic               v1_q;
  logic [IDX_W-1:0]   idx1_q;
  logic signed [31:0] g1_q, w1_q;
  logic [32:0]        pa1_q, pb1_q;
  logic [31:0]        m_rd_q;
  logic [63:0]        v_rd_q;
  // stage 2
  logic               v2_q;
  logic [IDX_W-1:0]   idx2_q;
  logic signed [31:0] w2_q;
  logic [32:0]        pa2_q, pb2_q;
  logic signed [64:0] pma2_q;
  logic signed [65:0] pmb2_q;
  logic [63:0]        gg2_q, pvh2_q, pvl2_q;
  // stage 3
  logic               v3_q;
  logic [IDX_W-1:0]   idx3_q;
  logic signed [31:0] w3_q, m3_q;
  logic [32:0]        pa3_q, pb3_q;
  logic [64:0]        pch3_q, pcl3_q;
  logic [63:0]        pvh3_q, pvl3_q;

  logic               mom_v_q;
  aou_pkg::mom_t      mom_q;

  logic [32:0]        c1, c2;
  logic [31:0]        gmag;
  logic signed [64:0] pma_d;
  logic signed [65:0] pmb_d;
  logic signed [65:0] msum;
  logic [65:0]        vlow;
  logic [63:0]        v_new;
  logic [32:0]        corr1, corr2;

  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic [31:0]      wr_m;
  logic [63:0]      wr_v;

  // index modulo the store depth by conditional subtraction
  always_comb begin
    logic [9:0] red;
    red = in_data_i.element_index;
    for (int k = 9; k >= 0; k--) begin
      if ((WEIGHT_COUNT << k) <= 1023) begin
        if (red >= 10'(WEIGHT_COUNT << k)) begin
          red = red - 10'(WEIGHT_COUNT << k);
        end
      end
    end
    rd_addr = IDX_W'(red);
  end

  // an element still being updated further down must be written back first
  assign hazard = (v1_q && (idx1_q == rd_addr)) ||
                  (v2_q && (idx2_q == rd_addr)) ||
                  (v3_q && (idx3_q == rd_addr));

  assign in_ready_o = en_i && !clr_busy_q && !hazard;
  assign accept     = in_valid_i && in_ready_o;

  assign pa_prod = pa_q * cfg_i.beta_first;
  assign pb_prod = pb_q * cfg_i.beta_second;
  assign pa_new  = in_data_i.step_start ? pa_prod[64:32] : pa_q;
  assign pb_new  = in_data_i.step_start ? pb_prod[64:32] : pb_q;

  assign c1    = aou_pkg::ONE_Q32 - {1'b0, cfg_i.beta_first};
  assign c2    = aou_pkg::ONE_Q32 - {1'b0, cfg_i.beta_second};
  assign gmag  = g1_q[31] ? 32'(-g1_q) : 32'(g1_q);
  assign pma_d = $signed({1'b0, cfg_i.beta_first}) * $signed(m_rd_q);
  assign pmb_d = $signed({1'b0, c1}) * g1_q;
  assign msum  = pma2_q + pmb2_q;

  assign vlow  = {2'b00, pvl3_q} + {1'b0, pcl3_q};
  assign v_new = pvh3_q + pch3_q[63:0] + 64'(vlow[65:32]);
  assign corr1 = (pa3_q == aou_pkg::ONE_Q32) ? aou_pkg::ONE_Q32 : aou_pkg::ONE_Q32 - pa3_q;
  assign corr2 = (pb3_q == aou_pkg::ONE_Q32) ? aou_pkg::ONE_Q32 : aou_pkg::ONE_Q32 - pb3_q;

  assign wr_en   = clr_busy_q || (en_i && v3_q);
  assign wr_addr = clr_busy_q ? clr_cnt_q : idx3_q;
  assign wr_m    = clr_busy_q ? 32'd0 : 32'(m3_q);
  assign wr_v    = clr_busy_q ? 64'd0 : v_new;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q       <= 1'b0;
      v2_q       <= 1'b0;
      v3_q       <= 1'b0;
      mom_v_q    <= 1'b0;
      pa_q       <= aou_pkg::ONE_Q32;
      pb_q       <= aou_pkg::ONE_Q32;
      clr_busy_q <= 1'b1;
      clr_cnt_q  <= '0;
    end else begin
      if (clr_busy_q) begin
        if (clr_cnt_q == IDX_W'(WEIGHT_COUNT - 1)) begin
          clr_busy_q <= 1'b0;
        end else begin
          clr_cnt_q <= clr_cnt_q + 1'b1;
        end
      end
      if (en_i) begin
        v1_q    <= accept;
        v2_q    <= v1_q;
        v3_q    <= v2_q;
        mom_v_q <= v3_q;
      end
      if (accept) begin
        pa_q <= pa_new;
        pb_q <= pb_new;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      idx1_q <= rd_addr;
      g1_q   <= in_data_i.gradient;
      w1_q   <= in_data_i.weight_in;
      pa1_q  <= pa_new;
      pb1_q  <= pb_new;

      idx2_q <= idx1_q;
      w2_q   <= w1_q;
      pa2_q  <= pa1_q;
      pb2_q  <= pb1_q;
      pma2_q <= pma_d;
      pmb2_q <= pmb_d;
      gg2_q  <= gmag * gmag;
      pvh2_q <= cfg_i.beta_second * v_rd_q[63:32];
      pvl2_q <= cfg_i.beta_second * v_rd_q[31:0];

      idx3_q <= idx2_q;
      w3_q   <= w2_q;
      pa3_q  <= pa2_q;
      pb3_q  <= pb2_q;
      m3_q   <= msum[63:32];
      pch3_q <= c2 * gg2_q[63:32];
      pcl3_q <= c2 * gg2_q[31:0];
      pvh3_q <= pvh2_q;
      pvl3_q <= pvl2_q;

      mom_q.m     <= m3_q;
      mom_q.v     <= v_new;
      mom_q.corr1 <= corr1;
      mom_q.corr2 <= corr2;
      mom_q.w     <= w3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      m_mem[wr_addr] <= wr_m;
      v_mem[wr_addr] <= wr_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m_rd_q <= m_mem[rd_addr];
      v_rd_q <= v_mem[rd_addr];
    end
  end

  assign mom_valid_o = mom_v_q;
  assign mom_o       = mom_q;

endmodule

### hdl/aou_chk.sv
`timescale 1ns / 1ps

module aou_chk (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_i,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input aou_pkg::out_beat_t out_data_i
);

  logic        in_acc, out_acc;
  logic [15:0] cnt_q;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;

  // beats taken but not yet delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_q + 16'(in_acc) - 16'(out_acc);
    end
  end

  a_out_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> out_valid_i)
    else $error("result beat dropped before it was taken");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> $stable(out_data_i))
    else $error("stalled result beat changed");

  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (cnt_q != 16'd0))
    else $error("result beat without an outstanding input beat");

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (cnt_q == 16'd0) && !out_valid_i) |=> !out_valid_i)
    else $error("result appeared one cycle after its input");

endmodule

bind adam_optimizer_update aou_chk u_aou_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.data)
);
